// ===== rtl/etv_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes of the edge table vertex merge engine.
// No dependencies.
package etv_pkg;

    localparam logic [2:0] KIND_ADD   = 3'd0;
    localparam logic [2:0] KIND_MERGE = 3'd1;
    localparam logic [2:0] KIND_ADJ   = 3'd2;
    localparam logic [2:0] KIND_READ  = 3'd3;
    localparam logic [2:0] KIND_CLEAR = 3'd4;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_SAME  = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } state_t;

endpackage

// ===== rtl/etv_in_if.sv =====
`timescale 1ns / 1ps
// Input channel of the edge table vertex merge engine.
// Depends on nothing.
interface etv_in_if;
    logic              valid;
    logic              ready;
    logic [2:0]        kind;
    logic signed [15:0] first_x;
    logic signed [15:0] first_y;
    logic signed [15:0] second_x;
    logic signed [15:0] second_y;
    logic [9:0]        index_a;
    logic [9:0]        index_b;

    modport source (output valid, kind, first_x, first_y, second_x, second_y,
                    index_a, index_b, input ready);
    modport sink (input valid, kind, first_x, first_y, second_x, second_y,
                  index_a, index_b, output ready);
endinterface

// ===== rtl/etv_out_if.sv =====
`timescale 1ns / 1ps
// Output channel of the edge table vertex merge engine.
// Depends on nothing.
interface etv_out_if;
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic              adjacent;
    logic [9:0]        edge_total;
    logic [10:0]       vertex_total;
    logic signed [15:0] read_x;
    logic signed [15:0] read_y;
    logic [9:0]        read_start;
    logic [9:0]        read_end;

    modport source (output valid, status, adjacent, edge_total, vertex_total,
                    read_x, read_y, read_start, read_end, input ready);
    modport sink (input valid, status, adjacent, edge_total, vertex_total,
                  read_x, read_y, read_start, read_end, output ready);
endinterface

// ===== rtl/edge_table_vertex_merge_engine_top.sv =====
`timescale 1ns / 1ps
// Top level of the edge table vertex merge engine: two rings of cells and
// the sequencer that rotates them. Depends on etv_pkg, etv_in_if, etv_out_if
// and etv_cell.
//
//   channel | direction | carries
//   in_ch   | sink      | one command item (kind, coordinates, indices)
//   out_ch  | source    | one result item per command
//
// Accepted add, merge, adjacency and read items take one full ring rotation;
// clear, refused and unknown items skip the rotation.
// The result register lets the next item be taken while a result waits.
// Reset clears the counts; the cells hold no reset value.
module edge_table_vertex_merge_engine_top
    import etv_pkg::*;
#(
    parameter int MAX_EDGES    = 512,
    parameter int MAX_VERTICES = 1024,
    parameter int COORD_BITS   = 16
) (
    input logic clk,
    input logic rst_n,
    etv_in_if.sink    in_ch,
    etv_out_if.source out_ch
);

    localparam int LEN  = (MAX_VERTICES > MAX_EDGES) ? MAX_VERTICES : MAX_EDGES;
    localparam int PW   = $clog2(LEN);
    localparam int VIDX = $clog2(MAX_VERTICES);
    localparam int VCW  = $clog2(MAX_VERTICES + 1);
    localparam int ECW  = $clog2(MAX_EDGES + 1);
    localparam int CW0  = (VCW > ECW) ? VCW : ECW;
    localparam int CW   = ((CW0 > PW) ? CW0 : PW) + 11;
    localparam int VW   = 2 * COORD_BITS;
    localparam int EW   = 2 * VIDX;

    state_t state_reg;
    logic [PW-1:0]  step_reg;
    logic [VCW-1:0] vc_reg;
    logic [ECW-1:0] ec_reg;

    logic [2:0]  kind_reg;
    logic [VW-1:0] first_reg;
    logic [VW-1:0] second_reg;
    logic [9:0]  ia_reg;
    logic [9:0]  ib_reg;
    logic [VIDX-1:0] keep_reg;
    logic [VIDX-1:0] gone_reg;
    logic        vok_reg;
    logic        eok_reg;
    logic [1:0]  status_reg;
    logic [VW-1:0] cap_v_reg;
    logic [EW-1:0] cap_a_reg;
    logic [EW-1:0] cap_b_reg;

    logic        out_valid_reg;
    logic [1:0]  o_status_reg;
    logic        o_adj_reg;
    logic [9:0]  o_et_reg;
    logic [10:0] o_vt_reg;
    logic [15:0] o_rx_reg;
    logic [15:0] o_ry_reg;
    logic [9:0]  o_rs_reg;
    logic [9:0]  o_re_reg;

    logic [VW-1:0] vcell [MAX_VERTICES];
    logic [EW-1:0] ecell [MAX_EDGES];
    logic [VW-1:0] tail_v;
    logic [EW-1:0] tail_e;
    logic          step_v;
    logic          step_e;
    logic [CW-1:0] pos;
    logic          last_step;
    logic          out_free;

    logic [CW-1:0] ia_w, ib_w, vc_w, ec_w;
    logic [VIDX-1:0] hs, he, ns, ne, a1, a2, b1, b2;

    assign pos       = CW'(step_reg);
    assign last_step = (step_reg == PW'(LEN - 1));
    assign step_v    = (state_reg == S_RUN) && (pos < CW'(MAX_VERTICES));
    assign step_e    = (state_reg == S_RUN) && (pos < CW'(MAX_EDGES));
    assign out_free  = !out_valid_reg || out_ch.ready;

    assign ia_w = CW'(in_ch.index_a);
    assign ib_w = CW'(in_ch.index_b);
    assign vc_w = CW'(vc_reg);
    assign ec_w = CW'(ec_reg);

    genvar gi;
    generate
        for (gi = 0; gi < MAX_VERTICES; gi++)
        begin : g_vring
            if (gi == MAX_VERTICES - 1)
            begin : g_last
                etv_cell #(.W(VW)) u_cell (.clk(clk), .step(step_v), .din(tail_v),
                                           .dout(vcell[gi]));
            end
            else
            begin : g_mid
                etv_cell #(.W(VW)) u_cell (.clk(clk), .step(step_v), .din(vcell[gi+1]),
                                           .dout(vcell[gi]));
            end
        end
        for (gi = 0; gi < MAX_EDGES; gi++)
        begin : g_ering
            if (gi == MAX_EDGES - 1)
            begin : g_last
                etv_cell #(.W(EW)) u_cell (.clk(clk), .step(step_e), .din(tail_e),
                                           .dout(ecell[gi]));
            end
            else
            begin : g_mid
                etv_cell #(.W(EW)) u_cell (.clk(clk), .step(step_e), .din(ecell[gi+1]),
                                           .dout(ecell[gi]));
            end
        end
    endgenerate

    assign hs = ecell[0][EW-1 -: VIDX];
    assign he = ecell[0][VIDX-1:0];

    always_comb
    begin
        ns = hs;
        ne = he;
        if (hs == gone_reg)
        begin
            ns = keep_reg;
        end
        else if (hs > gone_reg)
        begin
            ns = hs - 1'b1;
        end
        if (he == gone_reg)
        begin
            ne = keep_reg;
        end
        else if (he > gone_reg)
        begin
            ne = he - 1'b1;
        end
    end

    always_comb
    begin
        tail_v = vcell[0];
        tail_e = ecell[0];
        if (kind_reg == KIND_ADD)
        begin
            if (pos == vc_w)
            begin
                tail_v = first_reg;
            end
            else if (pos == vc_w + 1'b1)
            begin
                tail_v = second_reg;
            end
            if (pos == ec_w)
            begin
                tail_e = {VIDX'(vc_reg), VIDX'(vc_reg + 1'b1)};
            end
        end
        else if (kind_reg == KIND_MERGE)
        begin
            if (pos >= CW'(gone_reg))
            begin
                tail_v = vcell[1];
            end
            tail_e = {ns, ne};
        end
    end

    assign a1 = cap_a_reg[EW-1 -: VIDX];
    assign a2 = cap_a_reg[VIDX-1:0];
    assign b1 = cap_b_reg[EW-1 -: VIDX];
    assign b2 = cap_b_reg[VIDX-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            vc_reg        <= '0;
            ec_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == S_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_ch.valid)
                    begin
                        unique case (in_ch.kind)
                            KIND_ADD:
                            begin
                                if (vc_w + 2 > CW'(MAX_VERTICES)
                                    || ec_w + 1 > CW'(MAX_EDGES))
                                begin
                                    status_reg <= ST_FULL;
                                    state_reg  <= S_DONE;
                                end
                                else
                                begin
                                    status_reg <= ST_DONE;
                                    state_reg  <= S_RUN;
                                end
                            end
                            KIND_MERGE:
                            begin
                                if (in_ch.index_a == in_ch.index_b)
                                begin
                                    status_reg <= ST_SAME;
                                    state_reg  <= S_DONE;
                                end
                                else if (ia_w >= vc_w || ib_w >= vc_w)
                                begin
                                    status_reg <= ST_RANGE;
                                    state_reg  <= S_DONE;
                                end
                                else
                                begin
                                    status_reg <= ST_DONE;
                                    state_reg  <= S_RUN;
                                end
                            end
                            KIND_ADJ:
                            begin
                                if (ia_w >= ec_w || ib_w >= ec_w)
                                begin
                                    status_reg <= ST_RANGE;
                                    state_reg  <= S_DONE;
                                end
                                else
                                begin
                                    status_reg <= ST_DONE;
                                    state_reg  <= S_RUN;
                                end
                            end
                            KIND_READ:
                            begin
                                if (ia_w >= vc_w && ia_w >= ec_w)
                                begin
                                    status_reg <= ST_RANGE;
                                    state_reg  <= S_DONE;
                                end
                                else
                                begin
                                    status_reg <= ST_DONE;
                                    state_reg  <= S_RUN;
                                end
                            end
                            KIND_CLEAR:
                            begin
                                status_reg <= ST_DONE;
                                state_reg  <= S_DONE;
                                vc_reg     <= '0;
                                ec_reg     <= '0;
                            end
                            default:
                            begin
                                status_reg <= ST_DONE;
                                state_reg  <= S_DONE;
                            end
                        endcase
                    end
                end
                S_RUN:
                begin
                    if (last_step)
                    begin
                        step_reg  <= '0;
                        state_reg <= S_DONE;
                        if (kind_reg == KIND_ADD)
                        begin
                            vc_reg <= vc_reg + 2'd2;
                            ec_reg <= ec_reg + 1'b1;
                        end
                        else if (kind_reg == KIND_MERGE)
                        begin
                            vc_reg <= vc_reg - 1'b1;
                        end
                    end
                    else
                    begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_ch.valid)
        begin
            kind_reg   <= in_ch.kind;
            first_reg  <= {COORD_BITS'(in_ch.first_x), COORD_BITS'(in_ch.first_y)};
            second_reg <= {COORD_BITS'(in_ch.second_x), COORD_BITS'(in_ch.second_y)};
            ia_reg     <= in_ch.index_a;
            ib_reg     <= in_ch.index_b;
            vok_reg    <= ia_w < vc_w;
            eok_reg    <= ia_w < ec_w;
            if (in_ch.index_a < in_ch.index_b)
            begin
                keep_reg <= VIDX'(in_ch.index_a);
                gone_reg <= VIDX'(in_ch.index_b);
            end
            else
            begin
                keep_reg <= VIDX'(in_ch.index_b);
                gone_reg <= VIDX'(in_ch.index_a);
            end
        end
        if (state_reg == S_RUN)
        begin
            if (pos == CW'(ia_reg))
            begin
                if (step_v)
                begin
                    cap_v_reg <= vcell[0];
                end
                if (step_e)
                begin
                    cap_a_reg <= ecell[0];
                end
            end
            if (pos == CW'(ib_reg) && step_e)
            begin
                cap_b_reg <= ecell[0];
            end
        end
        if (state_reg == S_DONE && out_free)
        begin
            o_status_reg <= status_reg;
            o_adj_reg    <= (kind_reg == KIND_ADJ) && (status_reg == ST_DONE)
                            && (a1 == b1 || a2 == b2 || a1 == b2 || a2 == b1);
            o_et_reg     <= 10'(ec_reg);
            o_vt_reg     <= 11'(vc_reg);
            o_rx_reg     <= (kind_reg == KIND_READ && vok_reg)
                            ? 16'(signed'(cap_v_reg[VW-1 -: COORD_BITS])) : '0;
            o_ry_reg     <= (kind_reg == KIND_READ && vok_reg)
                            ? 16'(signed'(cap_v_reg[COORD_BITS-1:0])) : '0;
            o_rs_reg     <= (kind_reg == KIND_READ && eok_reg) ? 10'(a1) : '0;
            o_re_reg     <= (kind_reg == KIND_READ && eok_reg) ? 10'(a2) : '0;
        end
    end

    assign in_ch.ready         = (state_reg == S_IDLE);
    assign out_ch.valid        = out_valid_reg;
    assign out_ch.status       = o_status_reg;
    assign out_ch.adjacent     = o_adj_reg;
    assign out_ch.edge_total   = o_et_reg;
    assign out_ch.vertex_total = o_vt_reg;
    assign out_ch.read_x       = o_rx_reg;
    assign out_ch.read_y       = o_ry_reg;
    assign out_ch.read_start   = o_rs_reg;
    assign out_ch.read_end     = o_re_reg;

`ifndef SYNTHESIS
    a_vc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CW'(vc_reg) <= CW'(MAX_VERTICES))
        else $error("vertex count beyond table size");
    a_ec_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CW'(ec_reg) <= CW'(MAX_EDGES))
        else $error("edge count beyond table size");
    a_step_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_RUN) |-> (step_reg == '0))
        else $error("step counter moved outside a rotation");
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised without a finished item");
`endif

endmodule

// ===== rtl/etv_cell.sv =====
`timescale 1ns / 1ps
// One storage cell of a rotating table ring.
// Takes its neighbor's entry whenever the ring steps.
module etv_cell #(
    parameter int W = 32
) (
    input  logic         clk,
    input  logic         step,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] data_reg;

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            data_reg <= din;
        end
    end

    assign dout = data_reg;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of edge_table_vertex_merge_engine_top: directed table, then
// random commands, checked by a local graph predictor; typed rows hold their results.
// Depends on etv_pkg, etv_in_if, etv_out_if and the engine RTL.
module tb
    import etv_pkg::*;
();

    localparam int EDGE_CAP   = 512;
    localparam int VERTEX_CAP = 1024;
    localparam int SETTLE     = 2100;

    localparam logic [2:0] KIND_RSV5 = 3'd5;
    localparam logic [2:0] KIND_RSV6 = 3'd6;
    localparam logic [2:0] KIND_RSV7 = 3'd7;

    typedef struct {
        logic [2:0]         kind;
        logic signed [15:0] fx;
        logic signed [15:0] fy;
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic [9:0]         ia;
        logic [9:0]         ib;
    } cmd_t;

    typedef struct {
        logic [1:0]         status;
        logic               adjacent;
        logic [9:0]         edge_total;
        logic [10:0]        vertex_total;
        logic signed [15:0] read_x;
        logic signed [15:0] read_y;
        logic [9:0]         read_start;
        logic [9:0]         read_end;
    } res_t;

    typedef struct {
        cmd_t c;
        bit   typed;
        res_t r;
    } row_t;

    logic clk;
    logic rst_n;

    etv_in_if  in_ch ();
    etv_out_if out_ch ();

    edge_table_vertex_merge_engine_top DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    logic signed [15:0] graph_x [VERTEX_CAP];
    logic signed [15:0] graph_y [VERTEX_CAP];
    logic [9:0]         edge_a [EDGE_CAP];
    logic [9:0]         edge_b [EDGE_CAP];
    int                 edge_cnt;
    int                 vert_cnt;

    res_t pending_results [$];
    row_t directed_rows [$];
    bit   failed;
    int   results_seen;
    int   burst_left;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #200ms;
        $display("** edge_table_vertex_merge_engine_top: FAILED **");
        $finish;
    end

    function automatic cmd_t mk(input logic [2:0] k, input int fx, input int fy,
                                input int sx, input int sy, input int a, input int b);
        cmd_t c;
        c.kind = k;
        c.fx = fx[15:0];
        c.fy = fy[15:0];
        c.sx = sx[15:0];
        c.sy = sy[15:0];
        c.ia = a[9:0];
        c.ib = b[9:0];
        return c;
    endfunction

    function automatic res_t mkres(input logic [1:0] st, input int adj, input int e,
                                   input int v, input int x, input int y,
                                   input int s, input int en);
        res_t r;
        r.status = st;
        r.adjacent = adj[0];
        r.edge_total = e[9:0];
        r.vertex_total = v[10:0];
        r.read_x = x[15:0];
        r.read_y = y[15:0];
        r.read_start = s[9:0];
        r.read_end = en[9:0];
        return r;
    endfunction

    function automatic res_t graph_apply(input cmd_t c);
        res_t r;
        int keep;
        int gone;
        int ia;
        int ib;
        bit vok;
        bit eok;
        r = mkres(ST_DONE, 0, 0, 0, 0, 0, 0, 0);
        ia = c.ia;
        ib = c.ib;
        case (c.kind)
            KIND_ADD:
            begin
                if (vert_cnt + 2 > VERTEX_CAP || edge_cnt + 1 > EDGE_CAP)
                    r.status = ST_FULL;
                else
                begin
                    graph_x[vert_cnt] = c.fx;
                    graph_y[vert_cnt] = c.fy;
                    graph_x[vert_cnt + 1] = c.sx;
                    graph_y[vert_cnt + 1] = c.sy;
                    edge_a[edge_cnt] = vert_cnt[9:0];
                    edge_b[edge_cnt] = 10'(vert_cnt + 1);
                    vert_cnt += 2;
                    edge_cnt += 1;
                end
            end
            KIND_MERGE:
            begin
                if (ia == ib)
                    r.status = ST_SAME;
                else if (ia >= vert_cnt || ib >= vert_cnt)
                    r.status = ST_RANGE;
                else
                begin
                    keep = (ia < ib) ? ia : ib;
                    gone = (ia < ib) ? ib : ia;
                    for (int i = 0; i < edge_cnt; i++)
                    begin
                        if (edge_a[i] == gone)
                            edge_a[i] = keep[9:0];
                        else if (edge_a[i] > gone)
                            edge_a[i] = edge_a[i] - 1'b1;
                        if (edge_b[i] == gone)
                            edge_b[i] = keep[9:0];
                        else if (edge_b[i] > gone)
                            edge_b[i] = edge_b[i] - 1'b1;
                    end
                    for (int i = gone; i + 1 < vert_cnt; i++)
                    begin
                        graph_x[i] = graph_x[i + 1];
                        graph_y[i] = graph_y[i + 1];
                    end
                    vert_cnt -= 1;
                end
            end
            KIND_ADJ:
            begin
                if (ia >= edge_cnt || ib >= edge_cnt)
                    r.status = ST_RANGE;
                else
                    r.adjacent = (edge_a[ia] == edge_a[ib]) || (edge_b[ia] == edge_b[ib])
                              || (edge_a[ia] == edge_b[ib]) || (edge_b[ia] == edge_a[ib]);
            end
            KIND_READ:
            begin
                vok = ia < vert_cnt;
                eok = ia < edge_cnt;
                if (vok)
                begin
                    r.read_x = graph_x[ia];
                    r.read_y = graph_y[ia];
                end
                if (eok)
                begin
                    r.read_start = edge_a[ia];
                    r.read_end = edge_b[ia];
                end
                if (!vok && !eok)
                    r.status = ST_RANGE;
            end
            KIND_CLEAR:
            begin
                edge_cnt = 0;
                vert_cnt = 0;
            end
            default:
            begin
            end
        endcase
        r.edge_total = edge_cnt[9:0];
        r.vertex_total = vert_cnt[10:0];
        return r;
    endfunction

    task automatic offer(input cmd_t c, input bit typed, input res_t tr);
        res_t p;
        if (burst_left == 0)
        begin
            in_ch.valid <= 1'b0;
            if ($urandom_range(0, 7) == 0)
                repeat ($urandom_range(1, 1100)) @(posedge clk);
            else
                repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(1, 30);
        end
        in_ch.valid <= 1'b1;
        in_ch.kind <= c.kind;
        in_ch.first_x <= c.fx;
        in_ch.first_y <= c.fy;
        in_ch.second_x <= c.sx;
        in_ch.second_y <= c.sy;
        in_ch.index_a <= c.ia;
        in_ch.index_b <= c.ib;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        p = graph_apply(c);
        if (typed)
            p = tr;
        pending_results.insert(pending_results.size(), p);
        burst_left--;
    endtask

    task automatic offer_checked(input cmd_t c);
        offer(c, 1'b0, mkres(ST_DONE, 0, 0, 0, 0, 0, 0, 0));
    endtask

    function automatic int pick_vertex();
        return (vert_cnt > 0) ? $urandom_range(0, vert_cnt - 1) : $urandom_range(0, 1023);
    endfunction

    function automatic int pick_edge();
        return (edge_cnt > 0) ? $urandom_range(0, edge_cnt - 1) : $urandom_range(0, 1023);
    endfunction

    function automatic cmd_t random_cmd(input int add_weight);
        int sel;
        cmd_t c;
        c = mk(KIND_ADD, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        sel = $urandom_range(0, 99);
        if (sel < add_weight)
            c.kind = KIND_ADD;
        else if (sel < add_weight + 20)
        begin
            c.kind = KIND_MERGE;
            c.ia = 10'(pick_vertex());
            c.ib = 10'(pick_vertex());
        end
        else if (sel < add_weight + 35)
        begin
            c.kind = KIND_ADJ;
            c.ia = 10'(pick_edge());
            c.ib = 10'(pick_edge());
        end
        else if (sel < add_weight + 50)
        begin
            c.kind = KIND_READ;
            c.ia = 10'(pick_vertex());
        end
        else if (sel < 98)
            c.kind = 3'($urandom_range(KIND_MERGE, KIND_RSV7));
        else
            c.kind = KIND_CLEAR;
        return c;
    endfunction

    task automatic check_result();
        res_t e;
        if (pending_results.size() == 0)
        begin
            $error("result item with no expectation waiting");
            failed = 1'b1;
            return;
        end
        e = pending_results.pop_front();
        if (out_ch.status !== e.status)
        begin
            $error("status expected %0d got %0d", e.status, out_ch.status);
            failed = 1'b1;
        end
        if (out_ch.adjacent !== e.adjacent)
        begin
            $error("adjacent expected %0d got %0d", e.adjacent, out_ch.adjacent);
            failed = 1'b1;
        end
        if (out_ch.edge_total !== e.edge_total)
        begin
            $error("edge_total expected %0d got %0d", e.edge_total, out_ch.edge_total);
            failed = 1'b1;
        end
        if (out_ch.vertex_total !== e.vertex_total)
        begin
            $error("vertex_total expected %0d got %0d", e.vertex_total, out_ch.vertex_total);
            failed = 1'b1;
        end
        if (out_ch.read_x !== e.read_x)
        begin
            $error("read_x expected %0d got %0d", e.read_x, out_ch.read_x);
            failed = 1'b1;
        end
        if (out_ch.read_y !== e.read_y)
        begin
            $error("read_y expected %0d got %0d", e.read_y, out_ch.read_y);
            failed = 1'b1;
        end
        if (out_ch.read_start !== e.read_start)
        begin
            $error("read_start expected %0d got %0d", e.read_start, out_ch.read_start);
            failed = 1'b1;
        end
        if (out_ch.read_end !== e.read_end)
        begin
            $error("read_end expected %0d got %0d", e.read_end, out_ch.read_end);
            failed = 1'b1;
        end
    endtask

    // The receiver stalls in short random runs, with a single long hold-off that
    // lets the block fill up and stall its input.
    initial
    begin
        int stall_left;
        int hold_left;
        bit held;
        stall_left = 0;
        hold_left = 0;
        held = 1'b0;
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
            begin
                check_result();
                results_seen++;
            end
            if (!held && results_seen == 30)
            begin
                held = 1'b1;
                hold_left = 4000;
            end
            if (hold_left > 0)
                hold_left--;
            else if (stall_left > 0)
                stall_left--;
            else if ((results_seen / 50) % 2 == 1 && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 20);
            out_ch.ready <= (hold_left == 0) && (stall_left == 0);
        end
    end

    initial
    begin
        cmd_t c;
        failed = 1'b0;
        results_seen = 0;
        burst_left = 0;
        edge_cnt = 0;
        vert_cnt = 0;
        rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.kind <= KIND_ADD;
        in_ch.first_x <= '0;
        in_ch.first_y <= '0;
        in_ch.second_x <= '0;
        in_ch.second_y <= '0;
        in_ch.index_a <= '0;
        in_ch.index_b <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_rows = '{
            '{mk(KIND_READ, 0, 0, 0, 0, 0, 0), 1, mkres(ST_RANGE, 0, 0, 0, 0, 0, 0, 0)},
            '{mk(KIND_MERGE, 0, 0, 0, 0, 0, 0), 1, mkres(ST_SAME, 0, 0, 0, 0, 0, 0, 0)},
            '{mk(KIND_MERGE, 0, 0, 0, 0, 0, 1), 1, mkres(ST_RANGE, 0, 0, 0, 0, 0, 0, 0)},
            '{mk(KIND_ADJ, 0, 0, 0, 0, 0, 0), 1, mkres(ST_RANGE, 0, 0, 0, 0, 0, 0, 0)},
            '{mk(KIND_ADD, -32768, 32767, 32767, -32768, 1023, 1023), 1,
              mkres(ST_DONE, 0, 1, 2, 0, 0, 0, 0)},
            '{mk(KIND_ADD, 0, -1, 1, 21845, 0, 0), 1, mkres(ST_DONE, 0, 2, 4, 0, 0, 0, 0)},
            '{mk(KIND_READ, 0, 0, 0, 0, 0, 0), 1,
              mkres(ST_DONE, 0, 2, 4, -32768, 32767, 0, 1)},
            '{mk(KIND_READ, 0, 0, 0, 0, 1, 0), 1,
              mkres(ST_DONE, 0, 2, 4, 32767, -32768, 2, 3)},
            '{mk(KIND_READ, 0, 0, 0, 0, 3, 0), 1, mkres(ST_DONE, 0, 2, 4, 1, 21845, 0, 0)},
            '{mk(KIND_ADJ, 0, 0, 0, 0, 0, 1), 1, mkres(ST_DONE, 0, 2, 4, 0, 0, 0, 0)},
            '{mk(KIND_ADJ, 0, 0, 0, 0, 1, 1), 1, mkres(ST_DONE, 1, 2, 4, 0, 0, 0, 0)},
            '{mk(KIND_MERGE, 0, 0, 0, 0, 3, 0), 0, mkres(ST_DONE, 0, 0, 0, 0, 0, 0, 0)},
            '{mk(KIND_ADJ, 0, 0, 0, 0, 0, 1), 0, mkres(ST_DONE, 0, 0, 0, 0, 0, 0, 0)},
            '{mk(KIND_READ, 0, 0, 0, 0, 2, 0), 0, mkres(ST_DONE, 0, 0, 0, 0, 0, 0, 0)},
            '{mk(KIND_MERGE, 0, 0, 0, 0, 1, 2), 0, mkres(ST_DONE, 0, 0, 0, 0, 0, 0, 0)},
            '{mk(KIND_RSV5, 1, 2, 3, 4, 5, 6), 0, mkres(ST_DONE, 0, 0, 0, 0, 0, 0, 0)},
            '{mk(KIND_RSV6, -1, -1, -1, -1, 1023, 1023), 0, mkres(ST_DONE, 0, 0, 0, 0, 0, 0, 0)},
            '{mk(KIND_RSV7, 0, 0, 0, 0, 0, 0), 0, mkres(ST_DONE, 0, 0, 0, 0, 0, 0, 0)},
            '{mk(KIND_MERGE, 0, 0, 0, 0, 1023, 0), 0, mkres(ST_DONE, 0, 0, 0, 0, 0, 0, 0)},
            '{mk(KIND_ADJ, 0, 0, 0, 0, 0, 1023), 0, mkres(ST_DONE, 0, 0, 0, 0, 0, 0, 0)},
            '{mk(KIND_READ, 0, 0, 0, 0, 1023, 0), 0, mkres(ST_DONE, 0, 0, 0, 0, 0, 0, 0)},
            '{mk(KIND_CLEAR, 0, 0, 0, 0, 0, 0), 1, mkres(ST_DONE, 0, 0, 0, 0, 0, 0, 0)},
            '{mk(KIND_READ, 0, 0, 0, 0, 0, 0), 1, mkres(ST_RANGE, 0, 0, 0, 0, 0, 0, 0)}
        };
        foreach (directed_rows[i])
            offer(directed_rows[i].c, directed_rows[i].typed, directed_rows[i].r);

        repeat (300)
            offer_checked(random_cmd(40));

        // Let the block drain completely before the boundary items.
        in_ch.valid <= 1'b0;
        burst_left = 0;
        wait (pending_results.size() == 0);
        @(posedge clk);

        offer_checked(mk(KIND_READ, 0, 0, 0, 0, vert_cnt - 1, 0));
        offer_checked(mk(KIND_READ, 0, 0, 0, 0, 1023, 0));
        offer_checked(mk(KIND_ADJ, 0, 0, 0, 0, EDGE_CAP - 1, 0));
        offer_checked(mk(KIND_MERGE, 0, 0, 0, 0, vert_cnt - 1, 0));
        offer_checked(mk(KIND_ADD, -1, -1, -1, -1, 0, 0));
        offer_checked(mk(KIND_READ, 0, 0, 0, 0, EDGE_CAP - 1, 0));

        repeat (70)
            offer_checked(random_cmd(35));

        in_ch.valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (SETTLE) @(posedge clk);
        if (!failed && pending_results.size() == 0)
            $display("** edge_table_vertex_merge_engine_top: PASSED **");
        else
            $display("** edge_table_vertex_merge_engine_top: FAILED **");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/etv_pkg.sv
rtl/etv_in_if.sv
rtl/etv_out_if.sv
rtl/etv_cell.sv
rtl/edge_table_vertex_merge_engine_top.sv
tb/tb.sv
